[design/ihex_pkg.sv]
// Shared types and constants for the Intel HEX record parser.
// No dependencies.
`default_nettype none

package ihex_pkg;

    localparam int unsigned ADDR_BITS_DEF = 16;
    localparam int unsigned ADDR_W        = 16;
    localparam int unsigned CHAR_W        = 8;

    localparam logic [CHAR_W-1:0] COLON_CHAR = 8'h3A;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_HEAD = 2'd1,
        PH_DATA = 2'd2,
        PH_SUM  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_CSUM = 2'd2,
        KIND_FMT  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        HDR_COUNT  = 2'd0,
        HDR_ADDR_H = 2'd1,
        HDR_ADDR_L = 2'd2,
        HDR_TYPE   = 2'd3
    } t_hdr;

endpackage

`default_nettype wire

[design/intel_hex_record_parser.sv]
// Intel HEX record parser: one ASCII character in, at most one event out.
// Depends on ihex_pkg (types, phase and kind codes, constants).
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one character (i_char_in)
//   per transfer. Output channel o_out_valid / i_out_ready carries one event:
//   o_kind (data write, record ok, checksum error, format error), o_address,
//   o_data and o_record_type.
//   Each character is decoded in the cycle it is transferred; its event, if
//   any, appears on the output register the next cycle.
//   Throughput is one character per cycle, limited only by the single
//   output register: a new character is taken while the output is empty or
//   being drained in the same cycle.
//   When the receiver stalls with an event pending, o_in_ready drops until
//   that event is taken; characters that produce no event are held off too.
//   Reset returns the parser to waiting for a colon and empties the output.
//   ADDR_BITS sets the size of the target memory for the range check.
`default_nettype none

module intel_hex_record_parser #(
    parameter int unsigned ADDR_BITS = ihex_pkg::ADDR_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [ihex_pkg::CHAR_W-1:0]     i_char_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [1:0]                           o_kind,
    output logic [ihex_pkg::ADDR_W-1:0]          o_address,
    output logic [7:0]                           o_data,
    output logic [7:0]                           o_record_type
);

    localparam int unsigned AW = ihex_pkg::ADDR_W;
    localparam logic [AW:0] ADDR_LIMIT = (AW+1)'(1) << ADDR_BITS;

    ihex_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_high_nib, n_high_nib;
    logic             r_pending, n_pending;
    logic [1:0]       r_hdr_idx, n_hdr_idx;
    logic [7:0]       r_count, n_count;
    logic [7:0]       r_remain, n_remain;
    logic [AW-1:0]    r_waddr, n_waddr;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_sum, n_sum;

    logic             r_out_valid;
    ihex_pkg::t_kind  r_kind, n_kind;
    logic [AW-1:0]    r_address, n_address;
    logic [7:0]       r_data, n_data;
    logic [7:0]       r_rtype, n_rtype;

    logic             n_emit;
    logic             in_xfer;
    logic             nib_ok;
    logic [3:0]       nib;
    logic [7:0]       byte_val;
    logic [7:0]       sum_new;
    logic [7:0]       remain_dec;
    logic [AW:0]      end_addr;

    always_comb begin
        nib_ok = 1'b1;
        nib    = 4'd0;
        if (i_char_in >= 8'h30 && i_char_in <= 8'h39) begin
            nib = 4'(i_char_in - 8'h30);
        end else if (i_char_in >= 8'h41 && i_char_in <= 8'h46) begin
            nib = 4'(i_char_in - 8'h37);
        end else if (i_char_in >= 8'h61 && i_char_in <= 8'h66) begin
            nib = 4'(i_char_in - 8'h57);
        end else begin
            nib_ok = 1'b0;
        end
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign byte_val   = {r_high_nib, nib};
    assign sum_new    = r_sum + byte_val;
    assign remain_dec = r_remain - 8'd1;
    assign end_addr   = {1'b0, r_waddr} + {{(AW+1-8){1'b0}}, r_count};

    always_comb begin
        n_phase    = r_phase;
        n_high_nib = r_high_nib;
        n_pending  = r_pending;
        n_hdr_idx  = r_hdr_idx;
        n_count    = r_count;
        n_remain   = r_remain;
        n_waddr    = r_waddr;
        n_type     = r_type;
        n_sum      = r_sum;
        n_emit     = 1'b0;
        n_kind     = ihex_pkg::KIND_FMT;
        n_address  = '0;
        n_data     = '0;
        n_rtype    = '0;

        if (r_phase == ihex_pkg::PH_WAIT) begin
            if (i_char_in == ihex_pkg::COLON_CHAR) begin
                n_phase   = ihex_pkg::PH_HEAD;
                n_hdr_idx = ihex_pkg::HDR_COUNT;
                n_pending = 1'b0;
                n_sum     = '0;
                n_type    = '0;
            end
        end else if (!nib_ok) begin
            n_phase   = ihex_pkg::PH_WAIT;
            n_pending = 1'b0;
            n_emit    = 1'b1;
        end else if (!r_pending) begin
            n_high_nib = nib;
            n_pending  = 1'b1;
        end else begin
            n_pending = 1'b0;
            n_sum     = sum_new;
            case (r_phase)
                ihex_pkg::PH_HEAD: begin
                    n_hdr_idx = r_hdr_idx + 2'd1;
                    case (r_hdr_idx)
                        ihex_pkg::HDR_COUNT: begin
                            n_count  = byte_val;
                            n_remain = byte_val;
                        end
                        ihex_pkg::HDR_ADDR_H: begin
                            n_waddr = {byte_val, r_waddr[7:0]} & {8'hFF, 8'h00};
                        end
                        ihex_pkg::HDR_ADDR_L: begin
                            n_waddr = r_waddr | {8'h00, byte_val};
                        end
                        default: begin
                            n_type = byte_val;
                            if (end_addr > ADDR_LIMIT) begin
                                n_phase = ihex_pkg::PH_WAIT;
                                n_emit  = 1'b1;
                            end else if (r_remain == 8'd0) begin
                                n_phase = ihex_pkg::PH_SUM;
                            end else begin
                                n_phase = ihex_pkg::PH_DATA;
                            end
                        end
                    endcase
                end
                ihex_pkg::PH_DATA: begin
                    n_waddr   = r_waddr + AW'(1);
                    n_remain  = remain_dec;
                    if (remain_dec == 8'd0) begin
                        n_phase = ihex_pkg::PH_SUM;
                    end
                    n_emit    = 1'b1;
                    n_kind    = ihex_pkg::KIND_DATA;
                    n_address = r_waddr;
                    n_data    = byte_val;
                    n_rtype   = r_type;
                end
                default: begin
                    n_phase = ihex_pkg::PH_WAIT;
                    n_emit  = 1'b1;
                    n_kind  = (sum_new == 8'd0) ? ihex_pkg::KIND_OK : ihex_pkg::KIND_CSUM;
                    n_rtype = r_type;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ihex_pkg::PH_WAIT;
            r_high_nib <= '0;
            r_pending  <= 1'b0;
            r_hdr_idx  <= '0;
            r_count    <= '0;
            r_remain   <= '0;
            r_waddr    <= '0;
            r_type     <= '0;
            r_sum      <= '0;
        end else if (in_xfer) begin
            r_phase    <= n_phase;
            r_high_nib <= n_high_nib;
            r_pending  <= n_pending;
            r_hdr_idx  <= n_hdr_idx;
            r_count    <= n_count;
            r_remain   <= n_remain;
            r_waddr    <= n_waddr;
            r_type     <= n_type;
            r_sum      <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && n_emit) begin
            r_kind    <= n_kind;
            r_address <= n_address;
            r_data    <= n_data;
            r_rtype   <= n_rtype;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_address     = r_address;
    assign o_data        = r_data;
    assign o_record_type = r_rtype;

endmodule

`default_nettype wire

[verif/intel_hex_record_parser_tb.sv]
// Testbench for intel_hex_record_parser: directed records, then random HEX text with noise.
// Checks each event vs. built-in decoder or directed table, random stalls on both channels.
// Depends on ihex_pkg and the parser RTL.
`timescale 1ns / 1ps

module intel_hex_record_parser_tb;

    typedef struct packed {
        ihex_pkg::t_kind kind;
        logic [15:0]     address;
        logic [7:0]      data;
        logic [7:0]      rtype;
    } t_hex_event;

    typedef struct {
        logic [7:0] ch;
        bit         typed;
        t_hex_event ev;
    } t_stim_row;

    localparam t_hex_event NO_EVENT = '0;
    localparam int TARGET_CHARS = 1850;
    localparam int HOLD_CYCLES = 250;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_char_in = '0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic [15:0] o_address;
    logic [7:0] o_data;
    logic [7:0] o_record_type;

    // typed expectation travels with the character it belongs to
    bit         row_typed = 1'b0;
    t_hex_event row_ev = '0;

    // decoder state
    ihex_pkg::t_phase ps_phase = ihex_pkg::PH_WAIT;
    ihex_pkg::t_hdr   ps_hdr = ihex_pkg::HDR_COUNT;
    logic [3:0]  ps_hi = '0;
    bit          ps_pending = 1'b0;
    logic [7:0]  ps_count = '0;
    logic [7:0]  ps_left = '0;
    logic [15:0] ps_addr = '0;
    logic [7:0]  ps_type = '0;
    logic [7:0]  ps_sum = '0;

    t_hex_event expected_q[$];
    t_hex_event pred_ev;
    t_hex_event want;
    logic [7:0] text_q[$];

    int  mismatches = 0;
    int  parsed_chars = 0;
    int  sent_chars = 0;
    int  kind_seen[4] = '{0, 0, 0, 0};
    int  rx_wait = 0;
    int  rx_draw = 0;
    bit  rx_hold = 1'b0;
    bit  rx_steady = 1'b0;
    bit  tx_steady = 1'b0;

    t_stim_row dir_rows [26] = '{
        '{":", 1'b0, NO_EVENT},
        '{"0", 1'b0, NO_EVENT},
        '{"1", 1'b0, NO_EVENT},
        '{"f", 1'b0, NO_EVENT},
        '{"F", 1'b0, NO_EVENT},
        '{"F", 1'b0, NO_EVENT},
        '{"f", 1'b0, NO_EVENT},
        '{"0", 1'b0, NO_EVENT},
        '{"0", 1'b0, NO_EVENT},
        '{"A", 1'b0, NO_EVENT},
        '{"5", 1'b1, '{ihex_pkg::KIND_DATA, 16'hFFFF, 8'hA5, 8'h00}},
        '{"0", 1'b0, NO_EVENT},
        '{"0", 1'b1, '{ihex_pkg::KIND_CSUM, 16'h0000, 8'h00, 8'h00}},
        '{":", 1'b0, NO_EVENT},
        '{"0", 1'b0, NO_EVENT},
        '{"2", 1'b0, NO_EVENT},
        '{"F", 1'b0, NO_EVENT},
        '{"F", 1'b0, NO_EVENT},
        '{"F", 1'b0, NO_EVENT},
        '{"F", 1'b0, NO_EVENT},
        '{"0", 1'b0, NO_EVENT},
        '{"0", 1'b1, '{ihex_pkg::KIND_FMT, 16'h0000, 8'h00, 8'h00}},
        '{":", 1'b0, NO_EVENT},
        '{"g", 1'b1, '{ihex_pkg::KIND_FMT, 16'h0000, 8'h00, 8'h00}},
        '{":", 1'b0, NO_EVENT},
        '{":", 1'b1, '{ihex_pkg::KIND_FMT, 16'h0000, 8'h00, 8'h00}}
    };

    intel_hex_record_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_in     (i_char_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_address     (o_address),
        .o_data        (o_data),
        .o_record_type (o_record_type)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + {4'h0, n};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
    endfunction

    // Advances the decoder by one character; returns 1 when an event results.
    function automatic bit decode_char(input logic [7:0] c, output t_hex_event ev);
        logic [3:0] nib;
        logic [7:0] b;
        ev = '0;
        if (ps_phase == ihex_pkg::PH_WAIT) begin
            if (c == ihex_pkg::COLON_CHAR) begin
                ps_phase = ihex_pkg::PH_HEAD;
                ps_hdr = ihex_pkg::HDR_COUNT;
                ps_pending = 1'b0;
                ps_sum = '0;
                ps_type = '0;
            end
            return 1'b0;
        end
        if (!is_hex(c)) begin
            ps_phase = ihex_pkg::PH_WAIT;
            ps_pending = 1'b0;
            ev.kind = ihex_pkg::KIND_FMT;
            return 1'b1;
        end
        nib = (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
        if (!ps_pending) begin
            ps_hi = nib;
            ps_pending = 1'b1;
            return 1'b0;
        end
        ps_pending = 1'b0;
        b = {ps_hi, nib};
        ps_sum = ps_sum + b;
        case (ps_phase)
            ihex_pkg::PH_HEAD: begin
                case (ps_hdr)
                    ihex_pkg::HDR_COUNT: begin
                        ps_count = b;
                        ps_left = b;
                    end
                    ihex_pkg::HDR_ADDR_H: ps_addr = {b, 8'h00};
                    ihex_pkg::HDR_ADDR_L: ps_addr[7:0] = b;
                    default: begin
                        ps_type = b;
                        if (32'(ps_addr) + 32'(ps_count) >
                            (32'd1 << ihex_pkg::ADDR_BITS_DEF)) begin
                            ps_phase = ihex_pkg::PH_WAIT;
                            ev.kind = ihex_pkg::KIND_FMT;
                            return 1'b1;
                        end
                        ps_phase = (ps_left == 0) ? ihex_pkg::PH_SUM : ihex_pkg::PH_DATA;
                    end
                endcase
                ps_hdr = ihex_pkg::t_hdr'(ps_hdr + 2'd1);
                return 1'b0;
            end
            ihex_pkg::PH_DATA: begin
                ev = '{ihex_pkg::KIND_DATA, ps_addr, b, ps_type};
                ps_addr = ps_addr + 16'd1;
                ps_left = ps_left - 8'd1;
                if (ps_left == 0) ps_phase = ihex_pkg::PH_SUM;
                return 1'b1;
            end
            default: begin
                ps_phase = ihex_pkg::PH_WAIT;
                ev.kind = (ps_sum == 0) ? ihex_pkg::KIND_OK : ihex_pkg::KIND_CSUM;
                ev.rtype = ps_type;
                return 1'b1;
            end
        endcase
    endfunction

    task automatic send_char(input logic [7:0] ch, input bit typed, input t_hex_event ev);
        int gap;
        if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in <= ch;
        row_typed <= typed;
        row_ev <= ev;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // output side: check completed transfers first, then predict from the input transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ps_phase = ihex_pkg::PH_WAIT;
            ps_hdr = ihex_pkg::HDR_COUNT;
            ps_hi = '0;
            ps_pending = 1'b0;
            ps_count = '0;
            ps_left = '0;
            ps_addr = '0;
            ps_type = '0;
            ps_sum = '0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                kind_seen[o_kind] = kind_seen[o_kind] + 1;
                if (expected_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: unexpected event kind %0d addr %h data %h type %h",
                                 $time, o_kind, o_address, o_data, o_record_type);
                end else begin
                    want = expected_q.pop_front();
                    if (want.kind != o_kind || want.address != o_address ||
                        want.data != o_data || want.rtype != o_record_type) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch, expected kind %0d addr %h data %h ",
                                      "type %h, got kind %0d addr %h data %h type %h"},
                                     $time, want.kind, want.address, want.data, want.rtype,
                                     o_kind, o_address, o_data, o_record_type);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                sent_chars = sent_chars + 1;
                if (ps_phase != ihex_pkg::PH_WAIT || i_char_in == ihex_pkg::COLON_CHAR)
                    parsed_chars = parsed_chars + 1;
                if (decode_char(i_char_in, pred_ev) && !row_typed)
                    expected_q.push_back(pred_ev);
                if (row_typed)
                    expected_q.push_back(row_ev);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_wait <= 0;
        end else if (rx_hold) begin
            i_out_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            i_out_ready <= (rx_wait == 1);
        end else if (o_out_valid && i_out_ready) begin
            if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
            rx_draw = rx_steady ? 0 : $urandom_range(0, 13);
            rx_wait <= rx_draw;
            i_out_ready <= (rx_draw == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // long receiver hold-off so the output register fills and input stalls
    initial begin
        while (parsed_chars < 300) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int cnt;
        int rec_index;
        int r;
        int idx;
        logic [15:0] addr;
        logic [7:0] rtype;
        logic [7:0] sum;
        logic [7:0] noise;
        logic [7:0] body[$];

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].ev);

        rec_index = 0;
        while (sent_chars < TARGET_CHARS) begin
            if (rec_index == 6) begin
                cnt = 255;
                addr = 16'($urandom_range(0, 16'hFF01));
            end else begin
                cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 8);
                addr = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 48))
                                                   : 16'($urandom);
            end
            rtype = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));

            body.delete();
            body.push_back(8'(cnt));
            body.push_back(addr[15:8]);
            body.push_back(addr[7:0]);
            body.push_back(rtype);
            repeat (cnt) body.push_back(8'($urandom));
            sum = '0;
            foreach (body[i]) sum = sum + body[i];
            body.push_back(($urandom_range(0, 3) != 0) ? ~sum + 8'd1 : 8'($urandom));

            text_q.push_back(ihex_pkg::COLON_CHAR);
            foreach (body[i]) begin
                text_q.push_back(hex_char(body[i][7:4]));
                text_q.push_back(hex_char(body[i][3:0]));
            end

            // broken records: a stray character, or the line cut short
            r = $urandom_range(0, 19);
            if (r == 0) begin
                do noise = 8'($urandom); while (is_hex(noise));
                idx = $urandom_range(1, text_q.size() - 1);
                text_q[idx] = noise;
            end else if (r == 1) begin
                repeat ($urandom_range(1, text_q.size() - 1)) void'(text_q.pop_back());
            end

            repeat ($urandom_range(0, 3)) begin
                r = $urandom_range(0, 3);
                if (r == 0) noise = 8'h0D;
                else if (r == 1) noise = 8'h0A;
                else do noise = 8'($urandom); while (noise == ihex_pkg::COLON_CHAR);
                text_q.push_back(noise);
            end

            while (text_q.size() != 0) send_char(text_q.pop_front(), 1'b0, NO_EVENT);
            rec_index = rec_index + 1;
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d characters (%0d inside records) over %0d random records.",
                 sent_chars, parsed_chars, rec_index);
        $display("Events: %0d writes, %0d ok, %0d checksum errors, %0d format errors.",
                 kind_seen[ihex_pkg::KIND_DATA], kind_seen[ihex_pkg::KIND_OK],
                 kind_seen[ihex_pkg::KIND_CSUM], kind_seen[ihex_pkg::KIND_FMT]);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[files.f]
design/ihex_pkg.sv
design/intel_hex_record_parser.sv
verif/intel_hex_record_parser_tb.sv
